// ----- hw/rtl/cbf_pkg.sv -----
// Shared types and constants for the cubic Bezier flattener.
package cbf_pkg;
   localparam int TOL_BITS = 48;
   localparam int BUDGET_BITS = 7;
   localparam logic [TOL_BITS-1:0] TOL_RESET = 48'd65536;

   typedef struct packed {
      logic start;
      logic busy;
      logic done;
      logic near;
   } flat_ctl_type;
endpackage

// ----- hw/rtl/cubic_bezier_flattener_unit.sv -----
// A flatness test measures the distance to the start or end point when the point lies off
// the chord span and uses the cross product when it projects onto the chord; a piece needs
// one or two tests, an emit waits out any output stall, a piece with budget below 2 none.
// Throughput: one curve at a time, at most 64 pieces; req_ready returns after the last point
// is registered, as the state machine passes from emit through wait back to idle.
// Reset: synchronous, active high; clears control, tolerance returns to 65536.
module cubic_bezier_flattener_unit import cbf_pkg::*; #(
   parameter int MAX_POINTS = 64,
   parameter int COORD_BITS = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [COORD_BITS-1:0] req_start_x,
   input  logic signed [COORD_BITS-1:0] req_start_y,
   input  logic signed [COORD_BITS-1:0] req_ctrl1_x,
   input  logic signed [COORD_BITS-1:0] req_ctrl1_y,
   input  logic signed [COORD_BITS-1:0] req_ctrl2_x,
   input  logic signed [COORD_BITS-1:0] req_ctrl2_y,
   input  logic signed [COORD_BITS-1:0] req_end_x,
   input  logic signed [COORD_BITS-1:0] req_end_y,
   input  logic [BUDGET_BITS-1:0]       req_point_budget,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [COORD_BITS-1:0] rsp_point_x,
   output logic signed [COORD_BITS-1:0] rsp_point_y,
   output logic                         rsp_last_point,
   input  logic                         csr_write_enable,
   input  logic [TOL_BITS-1:0]          csr_write_data
);
   localparam int CB = COORD_BITS;
   localparam int DEPTH = 16;
   localparam int SPW = $clog2(DEPTH);
   localparam logic [2:0] S_IDLE = 3'd0, S_T1 = 3'd1, S_W1 = 3'd2, S_T2 = 3'd3,
      S_W2 = 3'd4, S_EMIT = 3'd5, S_WAIT = 3'd6, S_POP = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [TOL_BITS-1:0] tol_ff;
   logic signed [CB-1:0] x_ff [4];
   logic signed [CB-1:0] y_ff [4];
   logic [BUDGET_BITS-1:0] bud_ff;
   logic [SPW-1:0] sp_ff;
   logic [8*CB+BUDGET_BITS-1:0] stack_mem [DEPTH];
   logic [8*CB+BUDGET_BITS-1:0] pop_ff;
   logic ok1_ff;
   logic flat_start;
   logic signed [CB-1:0] fpx, fpy;
   flat_ctl_type fst;
   logic signed [CB-1:0] q0x, q1x, q2x, r0x, r1x, sx, q0y, q1y, q2y, r0y, r1y, sy;
   logic out_valid_ff, out_last_ff;
   logic signed [CB-1:0] out_x_ff, out_y_ff;

   function automatic logic signed [CB-1:0] avg(logic signed [CB-1:0] a,
                                                logic signed [CB-1:0] b);
      logic signed [CB:0] s;
      s = (CB+1)'(a) + (CB+1)'(b);
      return CB'(s >>> 1);
   endfunction

   assign q0x = avg(x_ff[0], x_ff[1]); assign q1x = avg(x_ff[1], x_ff[2]);
   assign q2x = avg(x_ff[2], x_ff[3]); assign r0x = avg(q0x, q1x);
   assign r1x = avg(q1x, q2x);         assign sx  = avg(r0x, r1x);
   assign q0y = avg(y_ff[0], y_ff[1]); assign q1y = avg(y_ff[1], y_ff[2]);
   assign q2y = avg(y_ff[2], y_ff[3]); assign r0y = avg(q0y, q1y);
   assign r1y = avg(q1y, q2y);         assign sy  = avg(r0y, r1y);

   // skip the distance unit when the budget alone ends the piece
   assign flat_start = (state_ff == S_T1 && bud_ff >= BUDGET_BITS'(2)) || (state_ff == S_T2);
   assign fpx = (state_ff == S_T1) ? x_ff[1] : x_ff[2];
   assign fpy = (state_ff == S_T1) ? y_ff[1] : y_ff[2];

   cbf_flat_unit #(.CoordBits(CB)) u_flat (
      .clock(clock), .reset(reset), .start(flat_start),
      .px(fpx), .py(fpy), .ax(x_ff[0]), .ay(y_ff[0]), .bx(x_ff[3]), .by(y_ff[3]),
      .tol(tol_ff), .status(fst));

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = out_valid_ff;
   assign rsp_point_x = out_x_ff;
   assign rsp_point_y = out_y_ff;
   assign rsp_last_point = out_last_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_valid) state_in = S_T1;
         S_T1:   state_in = (bud_ff < BUDGET_BITS'(2)) ? S_EMIT : S_W1;
         S_W1:   if (fst.done) state_in = fst.near ? S_T2 : S_T1;
         S_T2:   state_in = S_W2;
         S_W2:   if (fst.done) state_in = (fst.near && ok1_ff) ? S_EMIT : S_T1;
         S_EMIT: if (!out_valid_ff || rsp_ready) state_in = S_WAIT;
         S_WAIT: state_in = (out_last_ff) ? S_IDLE : S_POP;
         S_POP:  state_in = S_T1;
         default: state_in = S_IDLE;
      endcase
      // a failed first test splits at once
      if (state_ff == S_W1 && fst.done && !fst.near) state_in = S_T1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tol_ff       <= TOL_RESET;
         out_valid_ff <= 1'b0;
         sp_ff        <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) tol_ff <= csr_write_data;
         if (state_ff == S_EMIT && (!out_valid_ff || rsp_ready)) out_valid_ff <= 1'b1;
         else if (rsp_valid && rsp_ready) out_valid_ff <= 1'b0;
         if (state_ff == S_IDLE && req_valid) sp_ff <= '0;
         if (state_ff == S_WAIT && !out_last_ff) sp_ff <= sp_ff - 1'b1;
         if (((state_ff == S_W1 && !fst.near) || (state_ff == S_W2 && !(fst.near && ok1_ff)))
             && fst.done) sp_ff <= sp_ff + 1'b1;
      end
      if (state_ff == S_IDLE && req_valid) begin
         x_ff[0] <= req_start_x; y_ff[0] <= req_start_y;
         x_ff[1] <= req_ctrl1_x; y_ff[1] <= req_ctrl1_y;
         x_ff[2] <= req_ctrl2_x; y_ff[2] <= req_ctrl2_y;
         x_ff[3] <= req_end_x;   y_ff[3] <= req_end_y;
         bud_ff <= (req_point_budget > BUDGET_BITS'(MAX_POINTS > 64 ? 64 : MAX_POINTS))
                   ? BUDGET_BITS'(MAX_POINTS > 64 ? 64 : MAX_POINTS) : req_point_budget;
      end
      if (state_ff == S_W1 && fst.done) ok1_ff <= fst.near;
      // split: push the upper half, keep working on the lower half
      if (((state_ff == S_W1 && !fst.near) || (state_ff == S_W2 && !(fst.near && ok1_ff)))
          && fst.done) begin
         stack_mem[sp_ff] <= {sx, sy, r1x, r1y, q2x, q2y, x_ff[3], y_ff[3], bud_ff >> 1};
         bud_ff  <= bud_ff >> 1;
         x_ff[1] <= q0x; y_ff[1] <= q0y;
         x_ff[2] <= r0x; y_ff[2] <= r0y;
         x_ff[3] <= sx;  y_ff[3] <= sy;
      end
      if (state_ff == S_EMIT && (!out_valid_ff || rsp_ready)) begin
         out_x_ff    <= x_ff[3];
         out_y_ff    <= y_ff[3];
         out_last_ff <= (sp_ff == '0);
      end
      if (state_ff == S_WAIT) pop_ff <= stack_mem[sp_ff - 1'b1];
      if (state_ff == S_POP) begin
         {x_ff[0], y_ff[0], x_ff[1], y_ff[1], x_ff[2], y_ff[2], x_ff[3], y_ff[3], bud_ff}
            <= pop_ff;
      end
   end
endmodule

// ----- hw/rtl/cbf_flat_unit.sv -----
// Shared sequential unit: squared point-to-chord distance test, one multiply per cycle.
module cbf_flat_unit import cbf_pkg::*; #(
   parameter int CoordBits = 24
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic signed [CoordBits-1:0] px,
   input  logic signed [CoordBits-1:0] py,
   input  logic signed [CoordBits-1:0] ax,
   input  logic signed [CoordBits-1:0] ay,
   input  logic signed [CoordBits-1:0] bx,
   input  logic signed [CoordBits-1:0] by,
   input  logic [TOL_BITS-1:0]         tol,
   output flat_ctl_type                status
);
   localparam int DB = CoordBits + 1;
   localparam int PB = 2 * DB;
   localparam int SB = PB + 1;
   // limb width of the wide compare: cross, tolerance and length each fit in two limbs
   localparam int LB = ((SB + 1) / 2 > TOL_BITS / 2) ? (SB + 1) / 2 : TOL_BITS / 2;
   localparam int PW = 4 * LB;
   localparam int KB = (SB + 1 > TOL_BITS) ? SB + 1 : TOL_BITS;

   localparam logic [4:0] S_IDLE = 5'd0, S_UXWX = 5'd1, S_UYWY = 5'd2, S_UXUX = 5'd3,
      S_UYUY = 5'd4, S_UXWY = 5'd5, S_UYWX = 5'd6, S_D1 = 5'd7, S_D2 = 5'd8,
      S_DEC = 5'd9, S_C0 = 5'd10, S_C1 = 5'd11, S_C2 = 5'd12,
      S_T0 = 5'd14, S_T1 = 5'd15, S_T2 = 5'd16, S_T3 = 5'd17, S_CMP = 5'd18,
      S_DONE = 5'd19;

   logic [4:0] state_ff, state_in;
   logic signed [DB-1:0] ux_ff, uy_ff, wx_ff, wy_ff, ex_ff, ey_ff;
   logic signed [SB:0] acc_ff, acc_in, dot_ff, len_ff;
   logic [2*LB-1:0] cr_ff;
   logic [2*LB-1:0] tol_w, len_w;
   logic [PW-1:0] lhs_ff, rhs_ff;
   logic near_ff, near_in;
   logic signed [DB-1:0] ma, mb;
   logic signed [PB-1:0] prod;
   logic [LB-1:0] ua, ub;
   logic [2*LB-1:0] uprod;
   logic [TOL_BITS-1:0] tol_ff;

   assign prod  = ma * mb;
   assign uprod = ua * ub;
   assign tol_w = (2*LB)'(tol_ff);
   assign len_w = (2*LB)'($unsigned(len_ff));

   always_comb begin
      ma = '0; mb = '0; ua = '0; ub = '0;
      unique case (state_ff)
         S_UXWX: begin ma = ux_ff; mb = wx_ff; end
         S_UYWY: begin ma = uy_ff; mb = wy_ff; end
         S_UXUX: begin ma = ux_ff; mb = ux_ff; end
         S_UYUY: begin ma = uy_ff; mb = uy_ff; end
         S_UXWY: begin ma = ux_ff; mb = wy_ff; end
         S_UYWX: begin ma = uy_ff; mb = wx_ff; end
         S_D1:   begin ma = wx_ff; mb = wx_ff; end
         S_D2:   begin ma = wy_ff; mb = wy_ff; end
         S_C0:   begin ua = cr_ff[LB-1:0]; ub = cr_ff[LB-1:0]; end
         S_C1:   begin ua = cr_ff[LB-1:0]; ub = cr_ff[2*LB-1:LB]; end
         S_C2:   begin ua = cr_ff[2*LB-1:LB]; ub = cr_ff[2*LB-1:LB]; end
         S_T0:   begin ua = tol_w[LB-1:0]; ub = len_w[LB-1:0]; end
         S_T1:   begin ua = tol_w[LB-1:0]; ub = len_w[2*LB-1:LB]; end
         S_T2:   begin ua = tol_w[2*LB-1:LB]; ub = len_w[LB-1:0]; end
         S_T3:   begin ua = tol_w[2*LB-1:LB]; ub = len_w[2*LB-1:LB]; end
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      acc_in   = acc_ff;
      near_in  = near_ff;
      unique case (state_ff)
         S_IDLE: if (start) state_in = S_UXWX;
         S_UXWX: begin acc_in = (SB+1)'(prod); state_in = S_UYWY; end
         S_UYWY: begin acc_in = acc_ff + (SB+1)'(prod); state_in = S_UXUX; end
         S_UXUX: begin acc_in = (SB+1)'(prod); state_in = S_UYUY; end
         S_UYUY: begin acc_in = acc_ff + (SB+1)'(prod); state_in = S_UXWY; end
         S_UXWY: begin acc_in = (SB+1)'(prod); state_in = S_UYWX; end
         S_UYWX: begin acc_in = acc_ff - (SB+1)'(prod); state_in = S_DEC; end
         S_DEC: begin
            if (dot_ff <= 0) state_in = S_D1;
            else if (dot_ff > len_ff) state_in = S_D1;
            else state_in = S_C0;
         end
         S_D1: begin acc_in = (SB+1)'(prod); state_in = S_D2; end
         S_D2: begin
            near_in  = (KB'($unsigned(acc_ff + (SB+1)'(prod))) < KB'(tol_ff));
            state_in = S_DONE;
         end
         S_C0: state_in = S_C1;
         S_C1: state_in = S_C2;
         S_C2: state_in = S_T0;
         S_T0: state_in = S_T1;
         S_T1: state_in = S_T2;
         S_T2: state_in = S_T3;
         S_T3: state_in = S_CMP;
         S_CMP: begin near_in = (lhs_ff < rhs_ff); state_in = S_DONE; end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         near_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         near_ff  <= near_in;
      end
      acc_ff <= acc_in;
      unique case (state_ff)
         S_IDLE: if (start) begin
            ux_ff <= DB'(bx) - DB'(ax);
            uy_ff <= DB'(by) - DB'(ay);
            wx_ff <= DB'(px) - DB'(ax);
            wy_ff <= DB'(py) - DB'(ay);
            ex_ff <= DB'(px) - DB'(bx);
            ey_ff <= DB'(py) - DB'(by);
            tol_ff <= tol;
         end
         S_UXUX: dot_ff <= acc_ff;
         S_UXWY: len_ff <= acc_ff;
         S_DEC: begin
            cr_ff <= acc_ff[SB] ? (2*LB)'($unsigned(-acc_ff)) : (2*LB)'($unsigned(acc_ff));
            // beyond the chord end: measure from the end point
            if (!(dot_ff <= 0) && dot_ff > len_ff) begin
               wx_ff <= ex_ff;
               wy_ff <= ey_ff;
            end
            lhs_ff <= '0;
            rhs_ff <= '0;
         end
         // cross squared: the two middle limb products are equal, so add one twice
         S_C0: lhs_ff <= PW'(uprod);
         S_C1: lhs_ff <= lhs_ff + (PW'(uprod) << (LB + 1));
         S_C2: lhs_ff <= lhs_ff + (PW'(uprod) << (2 * LB));
         S_T0: rhs_ff <= PW'(uprod);
         S_T1: rhs_ff <= rhs_ff + (PW'(uprod) << LB);
         S_T2: rhs_ff <= rhs_ff + (PW'(uprod) << LB);
         S_T3: rhs_ff <= rhs_ff + (PW'(uprod) << (2 * LB));
         default: ;
      endcase
   end

   assign status.start = start;
   assign status.busy  = (state_ff != S_IDLE);
   assign status.done  = (state_ff == S_DONE);
   assign status.near  = near_ff;
endmodule

// ----- hw/rtl/cbf_checker.sv -----
// Port-level checker for the flattener, bound to the top level.
module cbf_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_last_point
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("rsp item dropped");
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("ready after accept");
   a_no_out_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid || rsp_last_point) else $error("point while idle");
endmodule

bind cubic_bezier_flattener_unit cbf_checker u_cbf_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_last_point(rsp_last_point));
